/* hdl/assert_macros.svh */
// Assertion helpers used by draw_batcher_with_clip_stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define CHECK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dbcs_pkg.sv */
package dbcs_pkg;

    localparam int COORD_W = 16;
    localparam int VERT_W  = 20;

    localparam logic [2:0] REQ_BEGIN = 3'd0;
    localparam logic [2:0] REQ_PUSH  = 3'd1;
    localparam logic [2:0] REQ_POP   = 3'd2;
    localparam logic [2:0] REQ_TEX   = 3'd3;
    localparam logic [2:0] REQ_VERT  = 3'd4;
    localparam logic [2:0] REQ_END   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_POP_BASE = 2'd2;
    localparam logic [1:0] ST_UNBAL    = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_rect;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    typedef struct packed {
        logic               has_batch;
        t_rect              clip;
        logic [COORD_W-1:0] texture;
        logic [VERT_W-1:0]  vertices;
        logic [1:0]         status;
    } t_result;

endpackage

/* hdl/dbcs_cell.sv */
module dbcs_cell import dbcs_pkg::*; (
    input  logic       i_clk,
    input  t_stack_ctl i_ctl,
    input  t_rect      i_prev,
    input  t_rect      i_next,
    output t_rect      o_entry
);

    t_rect r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_prev;
        end else if (i_ctl.pop) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

/* hdl/dbcs_clip.sv */
module dbcs_clip import dbcs_pkg::*; (
    input  logic signed [COORD_W-1:0] i_rect_x,
    input  logic signed [COORD_W-1:0] i_rect_y,
    input  logic        [COORD_W-1:0] i_rect_w,
    input  logic        [COORD_W-1:0] i_rect_h,
    input  t_rect                     i_cur,
    output t_rect                     o_rect
);

    // Returns the clipped start in the upper half and the clipped length in the lower half.
    function automatic logic [2*COORD_W-1:0] clip_axis(
        input logic signed [COORD_W-1:0] pos,
        input logic        [COORD_W-1:0] len,
        input logic        [COORD_W-1:0] cur_pos,
        input logic        [COORD_W-1:0] cur_len
    );
        logic signed [COORD_W+1:0] lo;
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] cur_lo;
        logic signed [COORD_W+1:0] cur_hi;
        logic signed [COORD_W+1:0] span;
        begin
            lo     = pos[COORD_W-1] ? '0 : (COORD_W+2)'(pos);
            hi     = (COORD_W+2)'(pos) + $signed({2'b00, len});
            cur_lo = $signed({2'b00, cur_pos});
            cur_hi = $signed({2'b00, cur_pos}) + $signed({2'b00, cur_len});
            if (hi < 0) begin
                hi = '0;
            end
            if (lo < cur_lo) begin
                lo = cur_lo;
            end
            if (hi > cur_hi) begin
                hi = cur_hi;
            end
            span = hi - lo;
            clip_axis = {lo[COORD_W-1:0], (hi > lo) ? span[COORD_W-1:0] : {COORD_W{1'b0}}};
        end
    endfunction

    logic [2*COORD_W-1:0] w_hor;
    logic [2*COORD_W-1:0] w_ver;

    assign w_hor = clip_axis(i_rect_x, i_rect_w, i_cur.x, i_cur.w);
    assign w_ver = clip_axis(i_rect_y, i_rect_h, i_cur.y, i_cur.h);

    assign o_rect.x = w_hor[2*COORD_W-1:COORD_W];
    assign o_rect.w = w_hor[COORD_W-1:0];
    assign o_rect.y = w_ver[2*COORD_W-1:COORD_W];
    assign o_rect.h = w_ver[COORD_W-1:0];

endmodule

/* hdl/draw_batcher_with_clip_stack.sv */
// Draw call batcher with a clip rectangle stack.
// The input channel (i_in_valid, o_in_stall) takes one draw request per cycle
// while o_in_stall is low: begin frame, push clip, pop clip, set texture, vertex
// or end frame. The output channel (o_out_valid, i_out_stall) delivers at most
// one result per request: a finished batch (clip, texture, vertex count) with a
// status code, or a status code alone. A request is fully handled in the cycle
// it is accepted; its result shows on the output ports in the next cycle unless
// the output register still holds a result not yet taken. The clip stack is a row of
// cells that shift one place on each push or pop, so no request waits on a memory.
// An output register and a skid register sit between the two channels. When
// the receiver stalls, requests are still taken until both hold a result;
// o_in_stall then rises until the skid register drains. Requests that give
// no result are taken only while o_in_stall is low as well.
// Reset clears the stack level, the current clip, texture and vertex count
// and empties both output registers; the stack cells themselves are not cleared.
`include "assert_macros.svh"

module draw_batcher_with_clip_stack import dbcs_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_req_type,
    input  logic signed [COORD_W-1:0] i_rect_x,
    input  logic signed [COORD_W-1:0] i_rect_y,
    input  logic [COORD_W-1:0]        i_rect_w,
    input  logic [COORD_W-1:0]        i_rect_h,
    input  logic [COORD_W-1:0]        i_texture_id,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_has_batch,
    output logic [COORD_W-1:0]        o_clip_x,
    output logic [COORD_W-1:0]        o_clip_y,
    output logic [COORD_W-1:0]        o_clip_w,
    output logic [COORD_W-1:0]        o_clip_h,
    output logic [COORD_W-1:0]        o_batch_texture,
    output logic [VERT_W-1:0]         o_batch_vertices,
    output logic [1:0]                o_status
);

    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(STACK_DEPTH);
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1);

    logic [LEVEL_W-1:0]    r_level, n_level;
    t_rect                 r_cur, n_cur;
    logic [COORD_W-1:0]    r_tex, n_tex;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_result               r_out, r_skid;
    logic                  r_ov, r_sv;

    logic                  w_accept;
    logic                  w_out_fire;
    t_stack_ctl            w_ctl;
    t_rect                 w_push_rect;
    t_rect                 w_isect;
    t_rect                 w_next_clip;
    t_rect                 w_entry [STACK_DEPTH];
    logic                  w_switch;
    logic                  w_has_res;
    t_result               w_res;
    t_result               w_batch;
    logic [VERT_W+COUNT_BITS-1:0] w_count_ext;

    assign w_accept   = i_in_valid && !r_sv;
    assign w_out_fire = r_ov && !i_out_stall;
    assign o_in_stall = r_sv;

    dbcs_clip u_clip (
        .i_rect_x (i_rect_x),
        .i_rect_y (i_rect_y),
        .i_rect_w (i_rect_w),
        .i_rect_h (i_rect_h),
        .i_cur    (r_cur),
        .o_rect   (w_isect)
    );

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        dbcs_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_prev  ((g == 0) ? w_push_rect : w_entry[(g == 0) ? 0 : g - 1]),
            .i_next  (w_entry[(g == STACK_DEPTH - 1) ? g : g + 1]),
            .o_entry (w_entry[g])
        );
    end

    assign w_count_ext = {{VERT_W{1'b0}}, r_count};

    always_comb begin
        w_batch.has_batch = 1'b1;
        w_batch.clip      = r_cur;
        w_batch.texture   = r_tex;
        w_batch.vertices  = w_count_ext[VERT_W-1:0];
        w_batch.status    = ST_OK;
    end

    always_comb begin
        n_level     = r_level;
        n_cur       = r_cur;
        n_tex       = r_tex;
        n_count     = r_count;
        w_ctl       = '0;
        w_push_rect = w_isect;
        w_next_clip = w_isect;
        w_switch    = 1'b0;
        w_has_res   = 1'b0;
        w_res       = '0;
        if (w_accept) begin
            case (i_req_type)
                REQ_BEGIN: begin
                    w_push_rect = '{x: '0, y: '0, w: i_rect_w, h: i_rect_h};
                    w_ctl.push  = 1'b1;
                    n_level     = LEVEL_ONE;
                    n_cur       = w_push_rect;
                    n_tex       = '0;
                    n_count     = '0;
                end
                REQ_PUSH: begin
                    if (r_level == LEVEL_MAX) begin
                        w_has_res    = 1'b1;
                        w_res.status = ST_OVERFLOW;
                    end else begin
                        w_ctl.push  = 1'b1;
                        n_level     = r_level + LEVEL_ONE;
                        w_switch    = 1'b1;
                        w_next_clip = w_isect;
                    end
                end
                REQ_POP: begin
                    if (r_level <= LEVEL_ONE) begin
                        w_has_res    = 1'b1;
                        w_res.status = ST_POP_BASE;
                    end else begin
                        w_ctl.pop   = 1'b1;
                        n_level     = r_level - LEVEL_ONE;
                        w_switch    = 1'b1;
                        w_next_clip = w_entry[1];
                    end
                end
                REQ_TEX: begin
                    if (i_texture_id != r_tex && r_count != '0) begin
                        w_has_res = 1'b1;
                        w_res     = w_batch;
                        n_count   = '0;
                    end
                    n_tex = i_texture_id;
                end
                REQ_VERT: begin
                    if (r_count != '1) begin
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_END: begin
                    if (r_count != '0 || r_level != LEVEL_ONE) begin
                        w_has_res    = 1'b1;
                        w_res        = (r_count != '0) ? w_batch : '0;
                        w_res.status = (r_level != LEVEL_ONE) ? ST_UNBAL : ST_OK;
                    end
                    n_level = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
            if (w_switch) begin
                if (w_next_clip != r_cur && r_count != '0) begin
                    w_has_res = 1'b1;
                    w_res     = w_batch;
                    n_count   = '0;
                end
                n_cur = w_next_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_cur   <= '0;
            r_tex   <= '0;
            r_count <= '0;
        end else begin
            r_level <= n_level;
            r_cur   <= n_cur;
            r_tex   <= n_tex;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_out_fire) begin
                r_sv <= 1'b0;
            end
        end else if (w_has_res) begin
            if (r_ov && !w_out_fire) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (w_has_res) begin
            if (r_ov && !w_out_fire) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_has_batch      = r_out.has_batch;
    assign o_clip_x         = r_out.clip.x;
    assign o_clip_y         = r_out.clip.y;
    assign o_clip_w         = r_out.clip.w;
    assign o_clip_h         = r_out.clip.h;
    assign o_batch_texture  = r_out.texture;
    assign o_batch_vertices = r_out.vertices;
    assign o_status         = r_out.status;

    `CHECK_ALWAYS(a_level_bound, r_level <= LEVEL_MAX, "Stack level beyond depth.")
    `CHECK_SAME(a_skid_needs_out, r_sv, r_ov, "Skid register full while output is empty.")
    `CHECK_SAME(a_skid_fill, $rose(r_sv), $past(r_ov) && $past(i_out_stall), "Bad skid fill.")
    `CHECK_NEXT(a_vertex_counts, w_accept && i_req_type == REQ_VERT, r_count != '0, "Vertex lost.")

endmodule
